FILE: hw/rtl/ber_oid_pkg.sv
package ber_oid_pkg;

    // Content buffer depth and the widths that follow from it.
    localparam int CONTENT_DEPTH = 32;
    localparam int ADDR_W        = $clog2(CONTENT_DEPTH);
    localparam int LEN_W         = 6;

    // Field widths.
    localparam int ARC_W  = 32;
    localparam int BYTE_W = 8;

    // Base-128 digits: the first subidentifier 40*X+Y needs 38 bits,
    // which is six groups of seven bits.
    localparam int GROUP_W = 7;
    localparam int GROUPS  = 6;
    localparam int SUB_W   = 38;
    localparam int SH_W    = GROUP_W * GROUPS;
    localparam int CNT_W   = 3;

    localparam logic [BYTE_W-1:0] OID_TAG = 8'h06;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ENC,
        ST_TAG,
        ST_LEN,
        ST_DATA
    } t_state;

    // Control from the sequencer to the content buffer.
    typedef struct packed {
        logic clear;
        logic advance;
    } t_store_ctrl;

    // Status from the content buffer back to the sequencer.
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              ovf;
        logic [BYTE_W-1:0] rd_data;
        logic              rd_last;
    } t_store_stat;

endpackage

FILE: hw/rtl/ber_oid_digits.sv
module ber_oid_digits (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ber_oid_pkg::SUB_W-1:0] i_value,
    output logic                          o_valid,
    output logic                          o_last,
    output logic [ber_oid_pkg::BYTE_W-1:0] o_byte
);

    logic [ber_oid_pkg::SH_W-1:0]  r_sh;
    logic [ber_oid_pkg::SH_W-1:0]  n_sh;
    logic [ber_oid_pkg::SH_W-1:0]  w_pad;
    logic [ber_oid_pkg::CNT_W-1:0] r_left;
    logic [ber_oid_pkg::CNT_W-1:0] w_groups;

    assign w_pad = {{(ber_oid_pkg::SH_W - ber_oid_pkg::SUB_W){1'b0}}, i_value};

    // Number of groups in the minimal encoding: one past the highest
    // nonzero group, and never less than one.
    always_comb begin
        w_groups = ber_oid_pkg::CNT_W'(1);
        for (int k = 0; k < ber_oid_pkg::GROUPS; k++) begin
            if (|w_pad[k*ber_oid_pkg::GROUP_W +: ber_oid_pkg::GROUP_W]) begin
                w_groups = ber_oid_pkg::CNT_W'(k + 1);
            end
        end
    end

    // Left-align the value so that the leading group sits at the top.
    always_comb begin
        n_sh = w_pad;
        for (int k = 1; k <= ber_oid_pkg::GROUPS; k++) begin
            if (w_groups == ber_oid_pkg::CNT_W'(k)) begin
                n_sh = w_pad << (ber_oid_pkg::GROUP_W * (ber_oid_pkg::GROUPS - k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_start) begin
            r_left <= w_groups;
        end else if (r_left != '0) begin
            r_left <= r_left - ber_oid_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh <= n_sh;
        end else begin
            r_sh <= r_sh << ber_oid_pkg::GROUP_W;
        end
    end

    assign o_valid = (r_left != '0);
    assign o_last  = (r_left == ber_oid_pkg::CNT_W'(1));
    assign o_byte  = {!o_last, r_sh[ber_oid_pkg::SH_W-1 -: ber_oid_pkg::GROUP_W]};

endmodule

FILE: hw/rtl/ber_oid_content.sv
module ber_oid_content (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [ber_oid_pkg::BYTE_W-1:0]  i_byte,
    input  ber_oid_pkg::t_store_ctrl        i_ctrl,
    output ber_oid_pkg::t_store_stat        o_stat
);

    logic [ber_oid_pkg::BYTE_W-1:0] r_mem [ber_oid_pkg::CONTENT_DEPTH];
    logic [ber_oid_pkg::LEN_W-1:0]  r_len;
    logic                           r_ovf;
    logic [ber_oid_pkg::ADDR_W-1:0] r_rd_ptr;
    logic [ber_oid_pkg::ADDR_W-1:0] n_rd_ptr;
    logic [ber_oid_pkg::BYTE_W-1:0] r_rd_data;
    logic                           w_room;

    assign w_room = (r_len < ber_oid_pkg::LEN_W'(ber_oid_pkg::CONTENT_DEPTH));

    always_comb begin
        if (i_ctrl.clear) begin
            n_rd_ptr = '0;
        end else if (i_ctrl.advance) begin
            n_rd_ptr = r_rd_ptr + ber_oid_pkg::ADDR_W'(1);
        end else begin
            n_rd_ptr = r_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_rd_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            if (i_ctrl.clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (i_push) begin
                if (w_room) begin
                    r_len <= r_len + ber_oid_pkg::LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // Write port, and a read port that follows the next read pointer so
    // the read data always matches the current pointer.
    always_ff @(posedge i_clk) begin
        if (i_push && w_room) begin
            r_mem[r_len[ber_oid_pkg::ADDR_W-1:0]] <= i_byte;
        end
        r_rd_data <= r_mem[n_rd_ptr];
    end

    assign o_stat.len     = r_len;
    assign o_stat.ovf     = r_ovf;
    assign o_stat.rd_data = r_rd_data;
    assign o_stat.rd_last = ((ber_oid_pkg::LEN_W'(r_rd_ptr) + ber_oid_pkg::LEN_W'(1)) == r_len);

endmodule

FILE: hw/rtl/ber_oid_encoder.sv
// Channel  | Direction | Handshake                | Payload
// arc      | in        | i_in_valid / o_in_stall  | i_arc_value[31:0], i_final_arc
// byte     | out       | o_out_valid / i_out_stall | o_out_byte[7:0], o_end_of_value,
//          |           |                          | o_overflowed
//
// A request that is not the last arc stalls the input through ST_LOAD and then ST_ENC,
// where ST_ENC holds for each of the G (one to six) base-128 groups of the
// subidentifier; a first arc that is not final is only stored, with no stall. The
// digit shifter emits one group per cycle into the content buffer.
// A final arc then sends the tag, the length and one content byte per
// cycle from the buffer's single read port while the output is not stalled.
// Reset is synchronous and active low; the buffer needs no clearing pass.
// A stalled output holds its register and pauses the drain sequence.
module ber_oid_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [ber_oid_pkg::ARC_W-1:0]    i_arc_value,
    input  logic                             i_final_arc,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [ber_oid_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                             o_end_of_value,
    output logic                             o_overflowed
);

    ber_oid_pkg::t_state      r_state;
    ber_oid_pkg::t_state      n_state;
    ber_oid_pkg::t_store_ctrl w_ctrl;
    ber_oid_pkg::t_store_stat w_stat;

    logic [1:0]                        r_arcs_seen;
    logic [ber_oid_pkg::ARC_W-1:0]     r_first;
    logic [ber_oid_pkg::SUB_W-1:0]     r_sub;
    logic [ber_oid_pkg::SUB_W-1:0]     n_sub;
    logic                              r_final;

    logic                              r_out_valid;
    logic [ber_oid_pkg::BYTE_W-1:0]    r_out_byte;
    logic                              r_out_eov;
    logic                              r_out_ovf;

    logic                              w_in_acc;
    logic                              w_out_load;
    logic                              w_emit;
    logic [ber_oid_pkg::BYTE_W-1:0]    w_byte;
    logic                              w_eov;
    logic                              w_start;

    logic                              w_dig_valid;
    logic                              w_dig_last;
    logic [ber_oid_pkg::BYTE_W-1:0]    w_dig_byte;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = !r_out_valid || !i_out_stall;

    // The second arc joins the first as 40*X+Y; 40*X is 32*X plus 8*X.
    // Later arcs pass through unchanged.
    always_comb begin
        if (r_arcs_seen == 2'd1) begin
            n_sub = ber_oid_pkg::SUB_W'(i_arc_value)
                  + ber_oid_pkg::SUB_W'({r_first, 5'b0})
                  + ber_oid_pkg::SUB_W'({r_first, 3'b0});
        end else begin
            n_sub = ber_oid_pkg::SUB_W'(i_arc_value);
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ber_oid_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (r_arcs_seen == 2'd0) begin
                        n_state = i_final_arc ? ber_oid_pkg::ST_TAG : ber_oid_pkg::ST_IDLE;
                    end else begin
                        n_state = ber_oid_pkg::ST_LOAD;
                    end
                end
            end
            ber_oid_pkg::ST_LOAD: begin
                n_state = ber_oid_pkg::ST_ENC;
            end
            ber_oid_pkg::ST_ENC: begin
                if (w_dig_valid && w_dig_last) begin
                    n_state = r_final ? ber_oid_pkg::ST_TAG : ber_oid_pkg::ST_IDLE;
                end
            end
            ber_oid_pkg::ST_TAG: begin
                if (w_out_load) begin
                    n_state = ber_oid_pkg::ST_LEN;
                end
            end
            ber_oid_pkg::ST_LEN: begin
                if (w_out_load) begin
                    n_state = (w_stat.len == '0) ? ber_oid_pkg::ST_IDLE
                                                 : ber_oid_pkg::ST_DATA;
                end
            end
            ber_oid_pkg::ST_DATA: begin
                if (w_out_load && w_stat.rd_last) begin
                    n_state = ber_oid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ber_oid_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic. With a single arc nothing was ever pushed, so the
    // normal path already gives the tag and a zero length with no overflow.
    always_comb begin
        o_in_stall     = 1'b1;
        w_start        = 1'b0;
        w_emit         = 1'b0;
        w_byte         = ber_oid_pkg::OID_TAG;
        w_eov          = 1'b0;
        w_ctrl.clear   = 1'b0;
        w_ctrl.advance = 1'b0;
        unique case (r_state)
            ber_oid_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ber_oid_pkg::ST_LOAD: begin
                w_start = 1'b1;
            end
            ber_oid_pkg::ST_ENC: begin
                w_start = 1'b0;
            end
            ber_oid_pkg::ST_TAG: begin
                w_emit = 1'b1;
            end
            ber_oid_pkg::ST_LEN: begin
                w_emit       = 1'b1;
                w_byte       = ber_oid_pkg::BYTE_W'(w_stat.len);
                w_eov        = (w_stat.len == '0);
                w_ctrl.clear = w_out_load && (w_stat.len == '0);
            end
            ber_oid_pkg::ST_DATA: begin
                w_emit         = 1'b1;
                w_byte         = w_stat.rd_data;
                w_eov          = w_stat.rd_last;
                w_ctrl.advance = w_out_load;
                w_ctrl.clear   = w_out_load && w_stat.rd_last;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ber_oid_pkg::ST_IDLE;
            r_arcs_seen <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctrl.clear) begin
                r_arcs_seen <= 2'd0;
            end else if (w_in_acc && r_arcs_seen != 2'd2) begin
                r_arcs_seen <= r_arcs_seen + 2'd1;
            end
            if (w_out_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // Request payload and the output register's payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sub   <= n_sub;
            r_final <= i_final_arc;
            if (r_arcs_seen == 2'd0) begin
                r_first <= i_arc_value;
            end
        end
        if (w_out_load && w_emit) begin
            r_out_byte <= w_byte;
            r_out_eov  <= w_eov;
            r_out_ovf  <= w_stat.ovf;
        end
    end

    ber_oid_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (r_sub),
        .o_valid (w_dig_valid),
        .o_last  (w_dig_last),
        .o_byte  (w_dig_byte)
    );

    ber_oid_content u_content (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_dig_valid),
        .i_byte  (w_dig_byte),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat)
    );

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_value = r_out_eov;
    assign o_overflowed   = r_out_ovf;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the BER object identifier encoder.
//
// Arcs go in one request at a time on the input channel. A scoreboard keeps
// its own copy of the encoder state: the arc count, the held first arc, the
// content bytes and the overflow bit. When an arc is accepted, the
// scoreboard works out every byte that arc should produce. Each accepted
// output byte is then compared with the oldest byte still expected.
//
// Stimulus starts with a few hand-picked identifiers. These cover a lone
// arc, both extremes of the arc value, each base-128 group boundary up to
// five groups, a huge first arc that needs six groups, and a content
// overflow that cuts an arc in the middle. After that come random
// identifiers of mixed length and magnitude. Both sides insert random idle
// cycles, with occasional stretches at full rate.
module tb_top;

    localparam int CYCLE_LIMIT      = 300000;
    // Random identifiers are sent until this many arcs in all have gone in.
    localparam int TOTAL_ARCS       = 215;
    localparam int DRAIN_CYCLES     = 16;
    localparam int FIRST_ARC_FACTOR = 40;
    localparam logic [ber_oid_pkg::BYTE_W-1:0] MORE_BIT = 8'h80;

    // One encoded output byte with its two flags.
    typedef struct packed {
        logic [ber_oid_pkg::BYTE_W-1:0] value;
        logic                           last;
        logic                           ovf;
    } t_enc_byte;

    // Tracks the encoder state and queues the bytes that it must send.
    class oid_scoreboard;
        int                             errors    = 0;
        logic [1:0]                     arcs_seen = '0;
        logic [ber_oid_pkg::ARC_W-1:0]  first_arc = '0;
        logic                           ovf       = 1'b0;
        logic [ber_oid_pkg::BYTE_W-1:0] content[$];
        t_enc_byte                      expected_bytes[$];

        function int pending();
            return expected_bytes.size();
        endfunction

        // A byte that finds the buffer full is lost and marks the overflow.
        function void put_content(logic [ber_oid_pkg::BYTE_W-1:0] b);
            if (content.size() < ber_oid_pkg::CONTENT_DEPTH) begin
                content.insert(content.size(), b);
            end else begin
                ovf = 1'b1;
            end
        endfunction

        // Minimal base-128, most significant group first. Every group but
        // the last carries the continuation bit.
        function void put_subid(logic [ber_oid_pkg::SUB_W-1:0] subid);
            logic [ber_oid_pkg::SUB_W-1:0]   rest;
            logic [ber_oid_pkg::GROUP_W-1:0] groups[ber_oid_pkg::GROUPS];
            int                              n;
            rest = subid;
            n = 0;
            do begin
                groups[n] = rest[ber_oid_pkg::GROUP_W-1:0];
                n++;
                rest = rest >> ber_oid_pkg::GROUP_W;
            end while (rest != 0);
            for (int i = n - 1; i >= 0; i--) begin
                put_content((i != 0) ? (MORE_BIT | ber_oid_pkg::BYTE_W'(groups[i]))
                                     : ber_oid_pkg::BYTE_W'(groups[i]));
            end
        endfunction

        function void note_arc(logic [ber_oid_pkg::ARC_W-1:0] arc, logic fin);
            t_enc_byte eb;
            if (arcs_seen == 2'd0) begin
                first_arc = arc;
                arcs_seen = 2'd1;
            end else if (arcs_seen == 2'd1) begin
                put_subid(ber_oid_pkg::SUB_W'(first_arc)
                          * ber_oid_pkg::SUB_W'(FIRST_ARC_FACTOR)
                          + ber_oid_pkg::SUB_W'(arc));
                arcs_seen = 2'd2;
            end else begin
                put_subid(ber_oid_pkg::SUB_W'(arc));
            end
            if (!fin) begin
                return;
            end
            // A lone arc gives just the tag and a zero length. Otherwise the
            // tag and the length come first, and then the buffered content.
            // The overflow bit is carried on every byte.
            if (arcs_seen < 2'd2) begin
                content.delete();
                ovf = 1'b0;
            end
            eb = '{value: ber_oid_pkg::OID_TAG, last: 1'b0, ovf: ovf};
            expected_bytes.insert(expected_bytes.size(), eb);
            eb = '{value: ber_oid_pkg::BYTE_W'(content.size()),
                   last: (content.size() == 0), ovf: ovf};
            expected_bytes.insert(expected_bytes.size(), eb);
            foreach (content[i]) begin
                eb = '{value: content[i], last: (i == content.size() - 1), ovf: ovf};
                expected_bytes.insert(expected_bytes.size(), eb);
            end
            arcs_seen = '0;
            first_arc = '0;
            ovf = 1'b0;
            content.delete();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_byte(logic [ber_oid_pkg::BYTE_W-1:0] got_byte, logic got_last,
                        logic got_ovf);
            t_enc_byte want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %02h sent with nothing expected", got_byte));
                return;
            end
            want = expected_bytes.pop_front();
            if (got_byte !== want.value)
                report($sformatf("byte %02h, expected %02h", got_byte, want.value));
            if (got_last !== want.last)
                report($sformatf("end_of_value %b on byte %02h, expected %b",
                                 got_last, want.value, want.last));
            if (got_ovf !== want.ovf)
                report($sformatf("overflowed %b on byte %02h, expected %b",
                                 got_ovf, want.value, want.ovf));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n        = 1'b0;
    logic                           i_in_valid     = 1'b0;
    logic                           o_in_stall;
    logic [ber_oid_pkg::ARC_W-1:0]  i_arc_value    = '0;
    logic                           i_final_arc    = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall    = 1'b0;
    logic [ber_oid_pkg::BYTE_W-1:0] o_out_byte;
    logic                           o_end_of_value;
    logic                           o_overflowed;

    oid_scoreboard sb = new;
    int  cycle_count = 0;
    int  arcs_sent   = 0;
    // When this is set, both sides run without idle cycles.
    logic no_idle    = 1'b0;

    ber_oid_encoder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_arc_value    (i_arc_value),
        .i_final_arc    (i_final_arc),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_end_of_value (o_end_of_value),
        .o_overflowed   (o_overflowed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A hung handshake or a lost byte ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Output monitor. Values are sampled before this edge updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_byte(o_out_byte, o_end_of_value, o_overflowed);
    end

    // Receiver back-pressure. Before each byte it draws a random stall, which may
    // be none. The stall is then held low until a byte is taken.
    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Sends one arc request. Valid stays high between back-to-back requests,
    // so that there is only one assignment to it in each time step.
    task automatic send_arc(input logic [ber_oid_pkg::ARC_W-1:0] value, input logic fin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_arc_value <= value;
        i_final_arc <= fin;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_arc(value, fin);
        arcs_sent++;
    endtask

    // Sends a whole identifier and flags its last arc as final.
    task automatic send_oid(input logic [ber_oid_pkg::ARC_W-1:0] arcs[$]);
        foreach (arcs[i])
            send_arc(arcs[i], i == arcs.size() - 1);
    endtask

    // Picks an arc that encodes to the requested number of groups, one to five.
    function automatic logic [ber_oid_pkg::ARC_W-1:0] arc_of_groups(int n);
        case (n)
            1: return $urandom_range(0, 127);
            2: return $urandom_range(128, 16383);
            3: return $urandom_range(16384, 2097151);
            4: return $urandom_range(2097152, 268435455);
            default: return $urandom_range(268435456, 32'hFFFF_FFFF);
        endcase
    endfunction

    initial begin
        logic [ber_oid_pkg::ARC_W-1:0] arcs[$];
        int                            n_arcs;
        int                            kind;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A lone arc at both extremes: only the tag and a zero length.
        send_oid('{32'd0});
        send_oid('{32'hFFFF_FFFF});
        // The smallest identifier, and the top of the usual first-arc range.
        send_oid('{32'd0, 32'd0});
        send_oid('{32'd2, 32'd39});
        // Each edge between one and four groups, and the largest four-group arc.
        send_oid('{32'd0, 32'd127, 32'd128, 32'd16383, 32'd16384,
                   32'd2097151, 32'd2097152, 32'd268435455});
        // A huge first arc: 40*X+Y needs all six groups.
        send_oid('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        // The content outgrows the buffer, so the last arc is cut mid-way.
        send_oid('{32'd1, 32'd2, 32'd268435456, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});

        // Random identifiers. Most are of ordinary length. Some are lone arcs,
        // and some are long enough to overflow.
        while (arcs_sent < TOTAL_ARCS) begin
            if ($urandom_range(0, 5) == 0)
                no_idle = ~no_idle;
            kind = $urandom_range(0, 9);
            if (kind == 0)
                n_arcs = 1;
            else if (kind == 1)
                n_arcs = $urandom_range(9, 16);
            else
                n_arcs = $urandom_range(2, 8);
            arcs.delete();
            // The first arc is mostly 0 to 2, as in real identifiers.
            arcs.insert(arcs.size(), ($urandom_range(0, 3) != 0) ? $urandom_range(0, 2)
                                                                  : $urandom());
            for (int i = 1; i < n_arcs; i++) begin
                if (kind == 1)
                    arcs.insert(arcs.size(), arc_of_groups($urandom_range(3, 5)));
                else
                    arcs.insert(arcs.size(), arc_of_groups($urandom_range(1, 5)));
            end
            send_oid(arcs);
        end
        i_in_valid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ber_oid_pkg.sv
hw/rtl/ber_oid_digits.sv
hw/rtl/ber_oid_content.sv
hw/rtl/ber_oid_encoder.sv
test/tb_top.sv
